FILE: design/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int NUM_PARTS = 8;
  localparam int PART_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CMP_W = (PART_W + 1 > 4) ? PART_W + 1 : 4;
  localparam int CNT_W = PART_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTS_IN_USE = 2'd1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [2:0]  load_index;
    logic [15:0] amount;
  } fpa_in_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  chosen_part;
    logic [15:0] space_left;
  } fpa_out_t;

  typedef struct packed {
    logic              found;
    logic [PART_W-1:0] pick;
    logic [15:0]       key;
  } srch_t;

  typedef struct packed {
    logic              en;
    logic [PART_W-1:0] idx;
    logic [15:0]       data;
  } wr_t;

endpackage

FILE: design/fpa_cell.sv
`timescale 1ns / 1ps
module fpa_cell import fpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PART_W-1:0] cell_idx,
  input  logic              active,
  input  logic [1:0]        mode,
  input  logic [15:0]       amt,
  input  wr_t               wr,
  input  srch_t             tok_in,
  output srch_t             tok_out
);

  logic [15:0] free_r;
  logic [15:0] free_nxt;
  srch_t       tok_r;
  srch_t       tok_nxt;
  logic        fits;
  logic        take;
  logic [15:0] left;

  always_comb begin
    free_nxt = free_r;
    if (wr.en && (wr.idx == cell_idx)) begin
      free_nxt = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
    end else begin
      free_r <= free_nxt;
    end
  end

  assign fits = active && (free_r >= amt);
  assign left = free_r - amt;

  always_comb begin
    tok_nxt = tok_in;
    case (mode)
      MODE_BEST: begin
        take = fits && (!tok_in.found || (left < tok_in.key));
        if (take) begin
          tok_nxt.key = left;
        end
      end
      MODE_WORST: begin
        take = fits && (!tok_in.found || (free_r > tok_in.key));
        if (take) begin
          tok_nxt.key = free_r;
        end
      end
      default: begin
        take = fits && !tok_in.found;
        if (take) begin
          tok_nxt.key = left;
        end
      end
    endcase
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.pick = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;

endmodule

FILE: design/fit_policy_partition_allocator.sv
`timescale 1ns / 1ps
// A load item writes its partition at the edge on which it is accepted.
// A request item walks the row of partition slots, one slot per cycle, and its
// result is registered once the walk is done and the output register is free;
// in_stall holds off every new item until then, so items do not overlap.
// Synchronous active-low reset clears all free space, sets first fit and eight
// partitions in use.
module fit_policy_partition_allocator import fpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fpa_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fpa_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SRCH = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      amt_r, amt_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [3:0]       parts_r, parts_nxt;
  logic             out_valid_r, out_valid_nxt;
  fpa_out_t         out_data_r, out_data_nxt;

  srch_t            tok [NUM_PARTS+1];
  logic [NUM_PARTS-1:0] active;
  wr_t              wr;
  logic             in_acc;
  logic             fin;
  logic [15:0]      left;
  logic [PART_W+2:0] pick_x;

  assign tok[0] = '0;

  for (genvar i = 0; i < NUM_PARTS; i++) begin : g_slot
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
    assign active[i] = IDX < CMP_W'(parts_r);
    fpa_cell u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (PART_W'(i)),
      .active   (active[i]),
      .mode     (mode_r),
      .amt      (amt_r),
      .wr       (wr),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign fin = (state_r == S_SRCH) && (cnt_r == CNT_W'(NUM_PARTS)) &&
               (!out_valid_r || !out_stall);
  assign left = (mode_r == MODE_WORST) ? tok[NUM_PARTS].key - amt_r : tok[NUM_PARTS].key;
  assign pick_x = (PART_W + 3)'(tok[NUM_PARTS].pick);

  always_comb begin
    wr = '0;
    if (fin) begin
      wr.en = tok[NUM_PARTS].found;
      wr.idx = tok[NUM_PARTS].pick;
      wr.data = left;
    end else if (in_acc && (in_data.kind == KIND_LOAD)) begin
      wr.en = CMP_W'(in_data.load_index) < CMP_W'(NUM_PARTS);
      wr.idx = PART_W'(in_data.load_index);
      wr.data = in_data.amount;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    amt_nxt = amt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.kind == KIND_REQUEST)) begin
          state_nxt = S_SRCH;
          cnt_nxt = '0;
          amt_nxt = in_data.amount;
        end
      end
      S_SRCH: begin
        if (cnt_r != CNT_W'(NUM_PARTS)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (fin) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = '0;
      if (tok[NUM_PARTS].found) begin
        out_data_nxt.granted = 1'b1;
        out_data_nxt.chosen_part = pick_x[2:0];
        out_data_nxt.space_left = left;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    parts_nxt = parts_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIT_MODE:     mode_nxt = cfg_data[1:0];
        REG_PARTS_IN_USE: parts_nxt = cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      mode_r <= MODE_FIRST;
      parts_r <= 4'd8;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      mode_r <= mode_nxt;
      parts_r <= parts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_r <= amt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_rise_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SRCH))
    else $error("result appeared without a finished search");

  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.granted) |->
      (out_data_r.chosen_part == 3'd0) && (out_data_r.space_left == 16'd0))
    else $error("refused item carries nonzero fields");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_PARTS))
    else $error("search counter overran the row");

  a_commit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && (state_r == S_SRCH)) |-> (fin && tok[NUM_PARTS].found))
    else $error("write-back without a granted search");
`endif

endmodule
